// ===== hdl/mdpq_pkg.sv =====
package mdpq_pkg;

  // Store geometry.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths fixed by the interface.
  localparam int VTX_W  = 16;
  localparam int DIST_W = 32;
  localparam int OCC_W  = 7;
  localparam int STAT_W = 2;

  // Operation codes.
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_WRITE,
    S_DONE
  } mdpq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_insert;
    logic set_empty;
    logic scan_start;
    logic scan_step;
    logic finish;
    logic load_out;
  } mdpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_extract;
    logic empty;
    logic scan_last;
    logic out_free;
  } mdpq_stat_t;

endpackage

// ===== hdl/mdpq_ctrl.sv =====
module mdpq_ctrl
  import mdpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  mdpq_stat_t stat,
  output mdpq_cmd_t  cmd
);

  mdpq_state_t state;
  mdpq_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (!stat.is_extract) begin
          cmd.do_insert = 1'b1;
          state_next    = S_DONE;
        end else if (stat.empty) begin
          cmd.set_empty = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last read entry is compared during this cycle.
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mdpq_datapath.sv =====
module mdpq_datapath
  import mdpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mdpq_cmd_t                cmd,
  output mdpq_stat_t               stat,
  input  logic                     func,
  input  logic [VTX_W-1:0]         vertex,
  input  logic signed [DIST_W-1:0] distance,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        status,
  output logic [VTX_W-1:0]         vertex_out,
  output logic [OCC_W-1:0]         occupancy
);

  localparam int ENTRY_W = VTX_W + DIST_W;

  // Entry store: vertex in the upper bits, distance in the lower bits.
  logic [ENTRY_W-1:0] mem [CAPACITY];

  // Latched request.
  logic                     item_func;
  logic [VTX_W-1:0]         item_vertex;
  logic signed [DIST_W-1:0] item_distance;

  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] count_idx;
  logic [IDX_W-1:0] last_idx;
  logic             full;
  logic             empty;

  // Scan read port and compare stage.
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_valid;
  logic [IDX_W-1:0]   rd_idx;
  logic signed [DIST_W-1:0] rd_dist;
  logic [VTX_W-1:0]   rd_vtx;
  logic               take;

  logic signed [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]         best_idx;
  logic [VTX_W-1:0]         best_vtx;
  logic [ENTRY_W-1:0]       last_entry;

  // Pending result.
  logic [STAT_W-1:0] res_status;
  logic [VTX_W-1:0]  res_vertex;

  logic out_free;

  assign count_idx = count[IDX_W-1:0];
  assign last_idx  = IDX_W'(count - CNT_W'(1));
  assign full      = (count >= CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign out_free  = !out_valid || !out_stall;

  assign rd_dist = rd_data[DIST_W-1:0];
  assign rd_vtx  = rd_data[ENTRY_W-1:DIST_W];
  // The first entry always wins; later ones only when strictly smaller.
  assign take    = (rd_idx == '0) || (rd_dist < best_dist);

  assign stat.is_extract = (item_func == FUNC_EXTRACT);
  assign stat.empty      = empty;
  assign stat.scan_last  = (rd_addr == last_idx);
  assign stat.out_free   = out_free;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func     <= func;
      item_vertex   <= vertex;
      item_distance <= distance;
    end
  end

  // Store writes and the registered scan read.
  always_ff @(posedge clk) begin
    if (cmd.do_insert && !full) begin
      mem[count_idx] <= {item_vertex, item_distance};
    end else if (cmd.finish) begin
      mem[best_idx] <= last_entry;
    end
    if (cmd.scan_step) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_insert && !full) begin
      count <= count + CNT_W'(1);
    end else if (cmd.finish) begin
      count <= count - CNT_W'(1);
    end
  end

  // Scan address and read-valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_step;
    end
    if (cmd.scan_start) begin
      rd_addr <= '0;
    end else if (cmd.scan_step) begin
      rd_addr <= rd_addr + IDX_W'(1);
    end
    if (cmd.scan_step) begin
      rd_idx <= rd_addr;
    end
  end

  // Running minimum, and capture of the last entry on its way past.
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      if (take) begin
        best_dist <= rd_dist;
        best_idx  <= rd_idx;
        best_vtx  <= rd_vtx;
      end
      if (rd_idx == last_idx) begin
        last_entry <= rd_data;
      end
    end
  end

  // Result status and vertex.
  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      res_status <= full ? STATUS_FULL : STATUS_DONE;
      res_vertex <= '0;
    end else if (cmd.set_empty) begin
      res_status <= STATUS_EMPTY;
      res_vertex <= '0;
    end else if (cmd.finish) begin
      res_status <= STATUS_DONE;
      res_vertex <= best_vtx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      status     <= res_status;
      vertex_out <= res_vertex;
      occupancy  <= OCC_W'(count);
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A removal only happens on a non-empty store and picks a live slot.
  a_finish_live: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!empty && (CNT_W'(best_idx) < count)))
    else $error("removal from an empty store or a dead slot");

  // A removal takes exactly one entry away.
  a_finish_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (count == $past(count) - CNT_W'(1)))
    else $error("removal did not decrement the count");

  // An accepted insert adds exactly one entry.
  a_insert_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_insert && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not increment the count");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result register overwritten");

endmodule

// ===== hdl/min_distance_priority_queue.sv =====
// Minimum-distance priority queue holding up to CAPACITY (vertex, distance)
// pairs in an unordered store. An insert (func 0) appends the pair, or reports
// status 1 when the store is full; an extract (func 1) returns the vertex with
// the smallest signed distance (lowest slot on ties), moves the last entry into
// the freed slot, or reports status 2 when the store is empty. Every request
// gives one result carrying the occupancy after the operation. Requests are
// handled one at a time: an insert or an empty extract is dispatched and then
// loads its result, and an extract on a store of N entries scans its N slots,
// drains the last compare and writes the last entry back before loading it;
// the single-port store reads one entry per cycle into one signed comparator.
// A new request is taken as soon as the previous result sits in the output
// register, even if it is still stalled there. The store needs no clearing
// after reset; only slots below the count are ever read.
module min_distance_priority_queue
  import mdpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     func,
  input  logic [VTX_W-1:0]         vertex,
  input  logic signed [DIST_W-1:0] distance,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        status,
  output logic [VTX_W-1:0]         vertex_out,
  output logic [OCC_W-1:0]         occupancy
);

  mdpq_cmd_t  cmd;
  mdpq_stat_t stat;

  // Sequencer.
  mdpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, comparator and result register.
  mdpq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .func       (func),
    .vertex     (vertex),
    .distance   (distance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .vertex_out (vertex_out),
    .occupancy  (occupancy)
  );

endmodule
